### rtl/core/oare_pkg.sv
// ---------------------------------------------------------------------------
// oare_pkg - shared types, constants and time arithmetic
// Seconds/nanoseconds time type and the clamping, saturating and wrapping helpers used by the
// configuration and execution stages of the alarm range extender.
// ---------------------------------------------------------------------------
package oare_pkg;

   localparam int SEC_W  = 32;
   localparam int NS_W   = 30;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;

   localparam logic [NS_W-1:0] NS_PER_SEC   = NS_W'(1000000000);
   localparam logic [NS_W-1:0] NS_MAX       = NS_W'(999999999);
   localparam logic [NS_W-1:0] NS_HALF_SEC  = NS_W'(500000000);

   // reset values of the interval registers
   localparam logic [SEC_W-1:0] MIN_SEC_RST = '0;
   localparam logic [NS_W-1:0]  MIN_NS_RST  = NS_W'(1000);
   localparam logic [SEC_W-1:0] MAX_SEC_RST = '0;
   localparam logic [NS_W-1:0]  MAX_NS_RST  = NS_W'(54925000);

   typedef enum logic [1:0] {
      OP_INIT        = 2'd0,
      OP_SET_ALARM   = 2'd1,
      OP_READ_TIME   = 2'd2,
      OP_EXPIRED     = 2'd3
   } op_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_MIN_SEC = 2'd0,
      CSR_MIN_NS  = 2'd1,
      CSR_MAX_SEC = 2'd2,
      CSR_MAX_NS  = 2'd3
   } csr_type;

   typedef struct packed {
      logic [SEC_W-1:0] sec;
      logic [NS_W-1:0]  nsec;
   } tv_type;

   typedef struct packed {
      tv_type min_iv;
      tv_type max_iv;
      tv_type half_min;
   } cfg_type;

   typedef struct packed {
      op_type operation;
      tv_type alarm;
      logic   notify;
      tv_type remain;
   } item_type;

   typedef struct packed {
      logic   reload_valid;
      tv_type reload;
      logic   alarm_fired;
      tv_type now;
   } result_type;

   localparam tv_type TV_ZERO = '{sec: '0, nsec: '0};

   // clamp nanoseconds into 0..999999999
   function automatic tv_type tv_norm(logic [SEC_W-1:0] s, logic [NS_W-1:0] ns);
      tv_type r;
      r.sec  = s;
      r.nsec = (ns > NS_MAX) ? NS_MAX : ns;
      return r;
   endfunction

   function automatic logic tv_le(tv_type a, tv_type b);
      return {a.sec, a.nsec} <= {b.sec, b.nsec};
   endfunction

   function automatic logic tv_lt(tv_type a, tv_type b);
      return {a.sec, a.nsec} < {b.sec, b.nsec};
   endfunction

   // seconds wrap, nanoseconds carry once
   function automatic tv_type tv_add(tv_type a, tv_type b);
      logic [NS_W:0] sum;
      logic          carry;
      tv_type        r;
      sum    = {1'b0, a.nsec} + {1'b0, b.nsec};
      carry  = (sum >= {1'b0, NS_PER_SEC});
      r.nsec = carry ? NS_W'(sum - {1'b0, NS_PER_SEC}) : sum[NS_W-1:0];
      r.sec  = a.sec + b.sec + SEC_W'(carry);
      return r;
   endfunction

   // a - b, zero when a <= b
   function automatic tv_type tv_sub_sat(tv_type a, tv_type b);
      logic [NS_W:0] diff;
      tv_type        r;
      if (tv_le(a, b)) begin
         r = TV_ZERO;
      end else if (a.nsec >= b.nsec) begin
         r.nsec = a.nsec - b.nsec;
         r.sec  = a.sec - b.sec;
      end else begin
         diff   = {1'b0, a.nsec} + {1'b0, NS_PER_SEC} - {1'b0, b.nsec};
         r.nsec = diff[NS_W-1:0];
         r.sec  = a.sec - b.sec - SEC_W'(1);
      end
      return r;
   endfunction

   // odd second contributes half a second to the nanoseconds
   function automatic tv_type tv_half(tv_type a);
      tv_type r;
      r.sec  = a.sec >> 1;
      r.nsec = (a.nsec >> 1) + (a.sec[0] ? NS_HALF_SEC : '0);
      return r;
   endfunction

endpackage

### rtl/core/oare_if.sv
// ---------------------------------------------------------------------------
// oare_if - channel interfaces
// Valid/ready channels for request beats, response beats and register writes.
// ---------------------------------------------------------------------------
interface oare_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                operation;
   logic [oare_pkg::SEC_W-1:0] alarm_sec;
   logic [oare_pkg::NS_W-1:0]  alarm_nsec;
   logic                      notify;
   logic [oare_pkg::SEC_W-1:0] remain_sec;
   logic [oare_pkg::NS_W-1:0]  remain_nsec;

   modport source (output valid, operation, alarm_sec, alarm_nsec, notify,
                   remain_sec, remain_nsec, input ready);
   modport sink   (input valid, operation, alarm_sec, alarm_nsec, notify,
                   remain_sec, remain_nsec, output ready);
endinterface

interface oare_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      reload_valid;
   logic [oare_pkg::SEC_W-1:0] reload_sec;
   logic [oare_pkg::NS_W-1:0]  reload_nsec;
   logic                      alarm_fired;
   logic [oare_pkg::SEC_W-1:0] time_sec;
   logic [oare_pkg::NS_W-1:0]  time_nsec;

   modport source (output valid, reload_valid, reload_sec, reload_nsec, alarm_fired,
                   time_sec, time_nsec, input ready);
   modport sink   (input valid, reload_valid, reload_sec, reload_nsec, alarm_fired,
                   time_sec, time_nsec, output ready);
endinterface

interface oare_csr_if;
   logic                        valid;
   logic                        ready;
   logic [oare_pkg::CSR_AW-1:0] index;
   logic [oare_pkg::CSR_DW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/oare_cfg.sv
// ---------------------------------------------------------------------------
// oare_cfg - interval registers
// Holds the minimum and maximum load intervals and derives half the minimum.
// ---------------------------------------------------------------------------
module oare_cfg (
   input  logic              clock,
   input  logic              reset,
   oare_csr_if.sink          csr_chan,
   output oare_pkg::cfg_type cfg
);

   logic [oare_pkg::SEC_W-1:0] min_sec_ff;
   logic [oare_pkg::NS_W-1:0]  min_ns_ff;
   logic [oare_pkg::SEC_W-1:0] max_sec_ff;
   logic [oare_pkg::NS_W-1:0]  max_ns_ff;
   oare_pkg::tv_type           min_iv;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_sec_ff <= oare_pkg::MIN_SEC_RST;
         min_ns_ff  <= oare_pkg::MIN_NS_RST;
         max_sec_ff <= oare_pkg::MAX_SEC_RST;
         max_ns_ff  <= oare_pkg::MAX_NS_RST;
      end else if (csr_chan.valid) begin
         unique case (oare_pkg::csr_type'(csr_chan.index))
            oare_pkg::CSR_MIN_SEC: min_sec_ff <= csr_chan.data[oare_pkg::SEC_W-1:0];
            oare_pkg::CSR_MIN_NS:  min_ns_ff  <= csr_chan.data[oare_pkg::NS_W-1:0];
            oare_pkg::CSR_MAX_SEC: max_sec_ff <= csr_chan.data[oare_pkg::SEC_W-1:0];
            oare_pkg::CSR_MAX_NS:  max_ns_ff  <= csr_chan.data[oare_pkg::NS_W-1:0];
         endcase
      end
   end

   // out-of-range nanoseconds clamp on use
   assign min_iv       = oare_pkg::tv_norm(min_sec_ff, min_ns_ff);
   assign cfg.min_iv   = min_iv;
   assign cfg.max_iv   = oare_pkg::tv_norm(max_sec_ff, max_ns_ff);
   assign cfg.half_min = oare_pkg::tv_half(min_iv);

endmodule

### rtl/core/oare_exec.sv
// ---------------------------------------------------------------------------
// oare_exec - clock, delay and load state with the per-operation update
// Works out one result from the held item and updates state on step.
// ---------------------------------------------------------------------------
module oare_exec (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  oare_pkg::item_type   item,
   input  oare_pkg::cfg_type    cfg,
   output oare_pkg::result_type result
);

   localparam oare_pkg::tv_type MAX_RST = '{sec: oare_pkg::MAX_SEC_RST,
                                            nsec: oare_pkg::MAX_NS_RST};

   oare_pkg::tv_type clock_ff, clock_in;
   oare_pkg::tv_type delay_ff, delay_in;
   oare_pkg::tv_type load_ff,  load_in;
   logic             armed_ff, armed_in;

   oare_pkg::tv_type remain;
   oare_pkg::tv_type request;
   oare_pkg::tv_type req_clamped;
   oare_pkg::tv_type now;
   oare_pkg::tv_type left;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= oare_pkg::TV_ZERO;
         delay_ff <= MAX_RST;
         load_ff  <= MAX_RST;
         armed_ff <= 1'b0;
      end else if (step) begin
         clock_ff <= clock_in;
         delay_ff <= delay_in;
         load_ff  <= load_in;
         armed_ff <= armed_in;
      end
   end

   // shared datapath pieces
   always_comb begin
      remain      = oare_pkg::tv_norm(item.remain.sec, item.remain.nsec);
      request     = oare_pkg::tv_norm(item.alarm.sec, item.alarm.nsec);
      req_clamped = oare_pkg::tv_lt(request, cfg.min_iv) ? cfg.min_iv : request;
      now         = oare_pkg::tv_add(clock_ff, oare_pkg::tv_sub_sat(load_ff, remain));
      left        = oare_pkg::tv_sub_sat(delay_ff, load_ff);
   end

   always_comb begin
      clock_in = clock_ff;
      delay_in = delay_ff;
      load_in  = load_ff;
      armed_in = armed_ff;
      result   = '{reload_valid: 1'b0, reload: oare_pkg::TV_ZERO,
                   alarm_fired: 1'b0, now: oare_pkg::TV_ZERO};
      unique case (item.operation)
         oare_pkg::OP_INIT: begin
            clock_in = oare_pkg::TV_ZERO;
            delay_in = cfg.max_iv;
            load_in  = cfg.max_iv;
         end
         oare_pkg::OP_SET_ALARM: begin
            clock_in = now;
            delay_in = req_clamped;
            armed_in = item.notify;
            load_in  = oare_pkg::tv_lt(cfg.max_iv, req_clamped) ? cfg.max_iv : req_clamped;
         end
         oare_pkg::OP_READ_TIME: begin
            result.now = now;
         end
         oare_pkg::OP_EXPIRED: begin
            clock_in = oare_pkg::tv_add(clock_ff, load_ff);
            if (oare_pkg::tv_le(left, cfg.half_min)) begin
               // alarm is due
               delay_in           = cfg.max_iv;
               load_in            = cfg.max_iv;
               result.alarm_fired = armed_ff;
               armed_in           = 1'b0;
            end else begin
               delay_in = left;
               load_in  = oare_pkg::tv_lt(left, cfg.max_iv) ? left : cfg.max_iv;
            end
         end
      endcase
      if (item.operation != oare_pkg::OP_READ_TIME) begin
         result.reload_valid = 1'b1;
         result.reload       = load_in;
      end
   end

endmodule

### rtl/core/one_shot_alarm_range_extender_unit.sv
// ---------------------------------------------------------------------------
// one_shot_alarm_range_extender_unit - long one-shot alarm over a short counter
// Top level: request register, execution stage, response register.
// ---------------------------------------------------------------------------
// Extends a short hardware down-counter into a long one-shot alarm and keeps
// system time in seconds plus nanoseconds. Each request beat carries one
// operation (init, set alarm, read time, counter expired) and yields exactly
// one response beat with the interval to load, an alarm-fired flag and, for
// read time, the current time. A request is held in an input register, the
// execution stage updates the clock, delay and load state and the response
// sits in an output register. Throughput is one beat per cycle while rsp_chan
// ready stays high; the rate is set by the state update in the execution
// stage, which each request reads as left by the one before. A response
// waiting for rsp_chan ready does not block the next request from entering
// an empty input register.
// Interval registers are written through csr_chan (always ready) and are
// meant to change only while no request is in flight.
// ---------------------------------------------------------------------------
module one_shot_alarm_range_extender_unit (
   input  logic       clock,
   input  logic       reset,
   oare_req_if.sink   req_chan,
   oare_rsp_if.source rsp_chan,
   oare_csr_if.sink   csr_chan
);

   // input stage
   logic                 in_valid_ff, in_valid_in;
   oare_pkg::item_type   item_ff,     item_in;
   // output stage
   logic                 out_valid_ff, out_valid_in;
   oare_pkg::result_type result_ff;

   oare_pkg::cfg_type    cfg;
   oare_pkg::result_type result;
   logic                 req_fire;
   logic                 out_free;
   logic                 advance;

   oare_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   oare_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // output register free this cycle, either empty or being drained
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.operation   = oare_pkg::op_type'(req_chan.operation);
      item_in.alarm.sec   = req_chan.alarm_sec;
      item_in.alarm.nsec  = req_chan.alarm_nsec;
      item_in.notify      = req_chan.notify;
      item_in.remain.sec  = req_chan.remain_sec;
      item_in.remain.nsec = req_chan.remain_nsec;
   end

   // valid flags for both stages
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.reload_valid = result_ff.reload_valid;
   assign rsp_chan.reload_sec   = result_ff.reload.sec;
   assign rsp_chan.reload_nsec  = result_ff.reload.nsec;
   assign rsp_chan.alarm_fired  = result_ff.alarm_fired;
   assign rsp_chan.time_sec     = result_ff.now.sec;
   assign rsp_chan.time_nsec    = result_ff.now.nsec;

endmodule

### rtl/core/oare_checker.sv
// ---------------------------------------------------------------------------
// oare_checker - port-level assertions
// Watches the response channel of the top level; attached by bind.
// ---------------------------------------------------------------------------
module oare_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       reload_valid,
   input logic [oare_pkg::SEC_W-1:0] reload_sec,
   input logic [oare_pkg::NS_W-1:0]  reload_nsec,
   input logic                       alarm_fired,
   input logic [oare_pkg::SEC_W-1:0] time_sec,
   input logic [oare_pkg::NS_W-1:0]  time_nsec
);

   // nothing pending straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(reload_valid) &&
         $stable(reload_sec) && $stable(reload_nsec) && $stable(alarm_fired) &&
         $stable(time_sec) && $stable(time_nsec))
      else $error("stalled response changed");

   // read time carries no load and never fires
   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !reload_valid |-> !alarm_fired && reload_sec == '0 &&
         reload_nsec == '0)
      else $error("read time response carries reload or fire");

   // only read time reports a time
   a_time_only_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && reload_valid |-> time_sec == '0 && time_nsec == '0)
      else $error("time reported on a reload response");

   // nanoseconds stay normalised
   a_ns_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> reload_nsec <= oare_pkg::NS_MAX && time_nsec <= oare_pkg::NS_MAX)
      else $error("nanoseconds out of range");

endmodule

bind one_shot_alarm_range_extender_unit oare_checker u_oare_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .reload_valid (rsp_chan.reload_valid),
   .reload_sec   (rsp_chan.reload_sec),
   .reload_nsec  (rsp_chan.reload_nsec),
   .alarm_fired  (rsp_chan.alarm_fired),
   .time_sec     (rsp_chan.time_sec),
   .time_nsec    (rsp_chan.time_nsec)
);
